FILE: hdl/lfuct_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache table package
// Codes, fixed widths and the control structs shared by the sequencer and the
// slot scan unit.
// ----------------------------------------------------------------------------
package lfuct_pkg;

   // Operation codes carried on the request tuser.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Widths of the item fields and of the capacity register.
   localparam int DATA_BITS = 32;
   localparam int CAP_BITS  = 5;

   // Capacity after reset.
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // Value returned by a get that misses.
   localparam logic [DATA_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   // Sequencer to scan unit: start clears the search, sample marks a slot
   // read that is on the bus this cycle.
   typedef struct packed {
      logic start;
      logic sample;
   } scan_ctrl_type;

   // Deferred recency update from the previous item.
   typedef struct packed {
      logic active;   // an update is waiting to be applied
      logic all;      // every other valid slot ages, regardless of rank
   } pend_flags_type;

   // What the scan has found so far.
   typedef struct packed {
      logic match;
      logic victim;
      logic free;
   } scan_status_type;

endpackage

FILE: hdl/lfu_cache_table_unit.sv
// Flow: an accepted item is swept slot by slot through the single read port of the
// slot memories, one slot per cycle, then committed; its result is registered.
// A new item is taken only once the last one has committed. A result still
// held at the port delays the commit, and with it the next item, by the stall.
// Reset: a clearing pass marks every slot invalid; requests are not taken until it
// ends. Capacity returns to 16; configuration is taken anytime.
// ----------------------------------------------------------------------------
// LFU cache table unit
// Key-value cache with least-frequently-used replacement and least-recent
// tie break. A sequencer sweeps the slots through a shared scan unit, then
// commits one update and registers the result.
// ----------------------------------------------------------------------------
module lfu_cache_table_unit #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request item.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,  // lookup_key, write_value
   input  logic                               req_tuser,  // operation
   // Result item.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,  // read_value, evicted_key
   output logic [1:0]                         rsp_tuser,  // hit, evicted
   // Capacity register write.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lfuct_pkg::CAP_BITS-1:0]     csr_data
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int MW = 1 + COUNT_BITS + AW;
   localparam int OW = $clog2(ENTRIES + 1);
   localparam int CW = (OW > lfuct_pkg::CAP_BITS) ? OW : lfuct_pkg::CAP_BITS;
   localparam int DW = lfuct_pkg::DATA_BITS;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [lfuct_pkg::CAP_BITS-1:0] capacity_ff, capacity_in;
   logic [OW-1:0]  in_use_ff, in_use_in;
   logic [AW-1:0]  clr_idx_ff, clr_idx_in;
   logic [OW-1:0]  issue_ff, issue_in;
   logic           samp_valid_ff;
   logic [AW-1:0]  samp_idx_ff;

   logic           op_ff;
   logic [DW-1:0]  key_ff;
   logic [DW-1:0]  val_ff;

   lfuct_pkg::pend_flags_type pend_ff, pend_in;
   logic [AW-1:0]  pend_slot_ff, pend_slot_in;
   logic [AW-1:0]  pend_thr_ff, pend_thr_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_hit_ff, rsp_hit_in;
   logic           rsp_ev_ff, rsp_ev_in;
   logic [DW-1:0]  rsp_rd_ff, rsp_rd_in;
   logic [DW-1:0]  rsp_evkey_ff, rsp_evkey_in;

   logic           accept;
   logic           upd_go;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [DW-1:0]  rd_key;
   logic [DW-1:0]  rd_value;
   logic [MW-1:0]  rd_meta;
   logic           meta_we;
   logic [AW-1:0]  meta_waddr;
   logic [MW-1:0]  meta_wdata;
   logic           kv_we;
   logic [AW-1:0]  kv_waddr;

   lfuct_pkg::scan_ctrl_type   scan_ctrl;
   lfuct_pkg::scan_status_type scan_status;
   logic [MW-1:0]         wb_meta;
   logic [AW-1:0]         match_idx;
   logic [DW-1:0]         match_value;
   logic [COUNT_BITS-1:0] match_count;
   logic [AW-1:0]         match_rank;
   logic [AW-1:0]         vic_idx;
   logic [DW-1:0]         vic_key;
   logic [AW-1:0]         vic_rank;
   logic [AW-1:0]         free_idx;

   logic [CW-1:0]         cap_ext;
   logic [CW-1:0]         cap_eff;
   logic                  need_evict;
   logic [COUNT_BITS-1:0] count_bump;

   // Handshakes.
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign upd_go     = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Capacity register.
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   // Effective capacity and the eviction test.
   assign cap_ext    = CW'(capacity_ff);
   assign cap_eff    = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
   assign need_evict = (CW'(in_use_ff) >= cap_eff);
   assign count_bump = (&match_count) ? match_count : (match_count + COUNT_BITS'(1));

   // Read sequencing: slot 0 is read on accept, the rest one per scan cycle.
   always_comb begin
      rd_en    = 1'b0;
      rd_addr  = '0;
      issue_in = issue_ff;
      if (state_ff == ST_IDLE) begin
         rd_en    = accept;
         issue_in = OW'(1);
      end else if ((state_ff == ST_SCAN) && (issue_ff != OW'(ENTRIES))) begin
         rd_en    = 1'b1;
         rd_addr  = issue_ff[AW-1:0];
         issue_in = issue_ff + OW'(1);
      end
   end

   assign scan_ctrl.start  = accept;
   assign scan_ctrl.sample = samp_valid_ff;

   // State sequencing.
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (samp_valid_ff && (samp_idx_ff == AW'(ENTRIES - 1))) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upd_go) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Memory writes, the commit of the item and the result.
   always_comb begin
      meta_we      = 1'b0;
      meta_waddr   = '0;
      meta_wdata   = '0;
      kv_we        = 1'b0;
      kv_waddr     = '0;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      pend_thr_in  = pend_thr_ff;
      in_use_in    = in_use_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_evkey_in = rsp_evkey_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_idx_ff;
         end
         ST_SCAN: begin
            // Write back the rank with the deferred update applied.
            meta_we    = samp_valid_ff;
            meta_waddr = samp_idx_ff;
            meta_wdata = wb_meta;
         end
         ST_UPDATE: begin
            if (upd_go) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = scan_status.match;
               rsp_ev_in    = 1'b0;
               rsp_evkey_in = '0;
               rsp_rd_in    = '0;
               pend_in      = '0;
               if (scan_status.match) begin
                  // Hit: bump the count and make the slot the most recent.
                  meta_we      = 1'b1;
                  meta_waddr   = match_idx;
                  meta_wdata   = {1'b1, count_bump, AW'(0)};
                  pend_in      = '{active: 1'b1, all: 1'b0};
                  pend_slot_in = match_idx;
                  pend_thr_in  = match_rank;
                  if (op_ff == lfuct_pkg::OP_PUT) begin
                     kv_we    = 1'b1;
                     kv_waddr = match_idx;
                  end else begin
                     rsp_rd_in = match_value;
                  end
               end else if (op_ff == lfuct_pkg::OP_GET) begin
                  rsp_rd_in = lfuct_pkg::MISS_VALUE;
               end else if (cap_eff != '0) begin
                  // Insert a new key, evicting a victim when full.
                  meta_we    = 1'b1;
                  meta_wdata = {1'b1, COUNT_BITS'(1), AW'(0)};
                  kv_we      = 1'b1;
                  pend_in    = '{active: 1'b1, all: !need_evict};
                  if (need_evict) begin
                     meta_waddr   = vic_idx;
                     kv_waddr     = vic_idx;
                     pend_slot_in = vic_idx;
                     pend_thr_in  = vic_rank;
                     rsp_ev_in    = 1'b1;
                     rsp_evkey_in = vic_key;
                  end else begin
                     meta_waddr   = free_idx;
                     kv_waddr     = free_idx;
                     pend_slot_in = free_idx;
                     pend_thr_in  = '0;
                     in_use_in    = in_use_ff + OW'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         capacity_ff   <= lfuct_pkg::CAP_RESET;
         in_use_ff     <= '0;
         clr_idx_ff    <= '0;
         issue_ff      <= '0;
         samp_valid_ff <= 1'b0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         capacity_ff   <= capacity_in;
         in_use_ff     <= in_use_in;
         clr_idx_ff    <= clr_idx_in;
         issue_ff      <= issue_in;
         samp_valid_ff <= rd_en;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      samp_idx_ff  <= rd_addr;
      pend_slot_ff <= pend_slot_in;
      pend_thr_ff  <= pend_thr_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_evkey_ff <= rsp_evkey_in;
      if (accept) begin
         op_ff  <= req_tuser;
         key_ff <= req_tdata[DW-1:0];
         val_ff <= req_tdata[2*DW-1:DW];
      end
   end

   lfuct_store #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_store (
      .clock      (clock),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_key     (rd_key),
      .rd_value   (rd_value),
      .rd_meta    (rd_meta),
      .meta_we    (meta_we),
      .meta_waddr (meta_waddr),
      .meta_wdata (meta_wdata),
      .kv_we      (kv_we),
      .kv_waddr   (kv_waddr),
      .kv_key     (key_ff),
      .kv_value   (val_ff)
   );

   lfuct_scan #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .samp_idx    (samp_idx_ff),
      .rd_meta     (rd_meta),
      .rd_key      (rd_key),
      .rd_value    (rd_value),
      .req_key     (key_ff),
      .pend        (pend_ff),
      .pend_slot   (pend_slot_ff),
      .pend_thr    (pend_thr_ff),
      .wb_meta     (wb_meta),
      .status      (scan_status),
      .match_idx   (match_idx),
      .match_value (match_value),
      .match_count (match_count),
      .match_rank  (match_rank),
      .vic_idx     (vic_idx),
      .vic_key     (vic_key),
      .vic_rank    (vic_rank),
      .free_idx    (free_idx)
   );

   // Result outputs.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_evkey_ff, rsp_rd_ff};
   assign rsp_tuser  = {rsp_ev_ff, rsp_hit_ff};

   // Occupancy never passes the number of slots.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= OW'(ENTRIES))
      else $error("occupancy above slot count");

   // Occupancy only moves when an item commits.
   a_occ_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPDATE) |=> $stable(in_use_ff))
      else $error("occupancy changed outside commit");

   // The scan write-back never lands on the slot being read.
   a_scan_ports: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && meta_we && rd_en) |-> (meta_waddr != rd_addr))
      else $error("scan write-back collides with read");

   // A commit always presents a result next cycle.
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPDATE) && upd_go) |=> rsp_valid_ff)
      else $error("commit without result");

   // An eviction only happens for a key that was absent.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ev_ff) |-> !rsp_hit_ff)
      else $error("eviction on a hit");

endmodule

FILE: hdl/lfuct_store.sv
// ----------------------------------------------------------------------------
// LFU cache table slot store
// Key, value and metadata memories. Metadata packs {valid, use count, rank}.
// Each memory has one write port and one registered read port.
// ----------------------------------------------------------------------------
module lfuct_store #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
   output logic [lfuct_pkg::DATA_BITS-1:0]       rd_key,
   output logic [lfuct_pkg::DATA_BITS-1:0]       rd_value,
   output logic [COUNT_BITS + ((ENTRIES > 1) ? $clog2(ENTRIES) : 1):0] rd_meta,
   input  logic                                  meta_we,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] meta_waddr,
   input  logic [COUNT_BITS + ((ENTRIES > 1) ? $clog2(ENTRIES) : 1):0] meta_wdata,
   input  logic                                  kv_we,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] kv_waddr,
   input  logic [lfuct_pkg::DATA_BITS-1:0]       kv_key,
   input  logic [lfuct_pkg::DATA_BITS-1:0]       kv_value
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int MW = 1 + COUNT_BITS + AW;

   logic [lfuct_pkg::DATA_BITS-1:0] key_mem   [ENTRIES];
   logic [lfuct_pkg::DATA_BITS-1:0] value_mem [ENTRIES];
   logic [MW-1:0]                   meta_mem  [ENTRIES];

   logic [lfuct_pkg::DATA_BITS-1:0] rd_key_ff;
   logic [lfuct_pkg::DATA_BITS-1:0] rd_value_ff;
   logic [MW-1:0]                   rd_meta_ff;

   // Key and value are written together when an item updates or fills a slot.
   always_ff @(posedge clock) begin
      if (kv_we) begin
         key_mem[kv_waddr]   <= kv_key;
         value_mem[kv_waddr] <= kv_value;
      end
   end

   // Metadata is written by the clearing pass, the scan write-back and updates.
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
   end

   // Registered read of all three memories at the same slot.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_value_ff <= value_mem[rd_addr];
         rd_meta_ff  <= meta_mem[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;
   assign rd_meta  = rd_meta_ff;

endmodule

FILE: hdl/lfuct_scan.sv
// ----------------------------------------------------------------------------
// LFU cache table slot scan unit
// Takes one slot per cycle. It applies the deferred recency update to the
// slot's rank, and keeps the running key match, the running eviction
// candidate (lowest count, then oldest touch) and the first free slot.
// ----------------------------------------------------------------------------
module lfuct_scan #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lfuct_pkg::scan_ctrl_type              ctrl,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] samp_idx,
   input  logic [COUNT_BITS + ((ENTRIES > 1) ? $clog2(ENTRIES) : 1):0] rd_meta,
   input  logic [lfuct_pkg::DATA_BITS-1:0]       rd_key,
   input  logic [lfuct_pkg::DATA_BITS-1:0]       rd_value,
   input  logic [lfuct_pkg::DATA_BITS-1:0]       req_key,
   input  lfuct_pkg::pend_flags_type             pend,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] pend_slot,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] pend_thr,
   output logic [COUNT_BITS + ((ENTRIES > 1) ? $clog2(ENTRIES) : 1):0] wb_meta,
   output lfuct_pkg::scan_status_type            status,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] match_idx,
   output logic [lfuct_pkg::DATA_BITS-1:0]       match_value,
   output logic [COUNT_BITS-1:0]                 match_count,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] match_rank,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] vic_idx,
   output logic [lfuct_pkg::DATA_BITS-1:0]       vic_key,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] vic_rank,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int MW = 1 + COUNT_BITS + AW;

   lfuct_pkg::scan_status_type      status_ff;
   lfuct_pkg::scan_status_type      status_in;
   logic [AW-1:0]                   match_idx_ff;
   logic [lfuct_pkg::DATA_BITS-1:0] match_value_ff;
   logic [COUNT_BITS-1:0]           match_count_ff;
   logic [AW-1:0]                   match_rank_ff;
   logic [AW-1:0]                   vic_idx_ff;
   logic [lfuct_pkg::DATA_BITS-1:0] vic_key_ff;
   logic [COUNT_BITS-1:0]           vic_count_ff;
   logic [AW-1:0]                   vic_rank_ff;
   logic [AW-1:0]                   free_idx_ff;

   logic                  m_valid;
   logic [COUNT_BITS-1:0] m_count;
   logic [AW-1:0]         m_rank;
   logic                  age;
   logic [AW-1:0]         adj_rank;
   logic                  is_match;
   logic                  is_victim;
   logic                  is_free;

   // Unpack the slot metadata.
   assign m_valid = rd_meta[MW-1];
   assign m_count = rd_meta[MW-2 -: COUNT_BITS];
   assign m_rank  = rd_meta[AW-1:0];

   // Deferred recency update: slots more recent than the one last touched, or every
   // other valid slot after an insert into a free slot, move back by one.
   assign age = pend.active && m_valid && (samp_idx != pend_slot) &&
                (pend.all || (m_rank < pend_thr));
   assign adj_rank = age ? (m_rank + AW'(1)) : m_rank;
   assign wb_meta  = {m_valid, m_count, adj_rank};

   // Shared compare unit: key match, eviction candidate and free slot.
   assign is_match  = ctrl.sample && m_valid && (rd_key == req_key) && !status_ff.match;
   assign is_victim = ctrl.sample && m_valid &&
                      (!status_ff.victim || (m_count < vic_count_ff) ||
                       ((m_count == vic_count_ff) && (adj_rank > vic_rank_ff)));
   assign is_free   = ctrl.sample && !m_valid && !status_ff.free;

   // Found flags restart with each item.
   always_comb begin
      status_in = status_ff;
      if (ctrl.start) begin
         status_in = '0;
      end else begin
         if (is_match)  status_in.match  = 1'b1;
         if (is_victim) status_in.victim = 1'b1;
         if (is_free)   status_in.free   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
      end else begin
         status_ff <= status_in;
      end
   end

   // Capture the data of whatever slot wins.
   always_ff @(posedge clock) begin
      if (is_match) begin
         match_idx_ff   <= samp_idx;
         match_value_ff <= rd_value;
         match_count_ff <= m_count;
         match_rank_ff  <= adj_rank;
      end
      if (is_victim) begin
         vic_idx_ff   <= samp_idx;
         vic_key_ff   <= rd_key;
         vic_count_ff <= m_count;
         vic_rank_ff  <= adj_rank;
      end
      if (is_free) begin
         free_idx_ff <= samp_idx;
      end
   end

   assign status      = status_ff;
   assign match_idx   = match_idx_ff;
   assign match_value = match_value_ff;
   assign match_count = match_count_ff;
   assign match_rank  = match_rank_ff;
   assign vic_idx     = vic_idx_ff;
   assign vic_key     = vic_key_ff;
   assign vic_rank    = vic_rank_ff;
   assign free_idx    = free_idx_ff;

endmodule

FILE: tb/lfu_cache_table_unit_tb.sv
// ----------------------------------------------------------------------------
// LFU cache table unit testbench
// Drives get and put items through the request stream, rewrites the capacity
// register between phases, and checks every result field against a cycle-free
// model of the cache: use counts, recency order, victim choice and free slots.
// A directed opening covers field extremes, capacity zero, a capacity lowered
// below occupancy and a frequently used key surviving evictions; random phases
// with bursty requests and a stalling receiver follow.
// ----------------------------------------------------------------------------
module lfu_cache_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int KEY_POOL   = 32;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_PRINTS = 100;
   localparam int HOT_HITS   = 24;

   // One expected result item, as the cache should report it.
   typedef struct packed {
      logic                            hit;
      logic [lfuct_pkg::DATA_BITS-1:0] read_value;
      logic                            evicted;
      logic [lfuct_pkg::DATA_BITS-1:0] evicted_key;
   } lookup_outcome_type;

   // Model of the cache contents plus the results still owed by the block.
   class cache_scoreboard_type;
      bit                              slot_live[ENTRIES];
      bit [lfuct_pkg::DATA_BITS-1:0]   slot_tag[ENTRIES];
      bit [lfuct_pkg::DATA_BITS-1:0]   slot_data[ENTRIES];
      bit [COUNT_BITS-1:0]             slot_uses[ENTRIES];
      int unsigned                     slot_age[ENTRIES];
      int unsigned                     occupancy;
      bit [lfuct_pkg::CAP_BITS-1:0]    capacity;
      lookup_outcome_type              awaited_outcomes[$];
      int unsigned                     mismatches;

      function new();
         capacity   = lfuct_pkg::CAP_RESET;
         occupancy  = 0;
         mismatches = 0;
         foreach (slot_live[i]) slot_live[i] = 1'b0;
      endfunction

      function void set_capacity(bit [lfuct_pkg::CAP_BITS-1:0] value);
         capacity = value;
      endfunction

      // Make slot s the most recent; the slots that were newer age by one.
      function void touch_slot(int unsigned s);
         int unsigned r;
         r = slot_age[s];
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && i != s && slot_age[i] < r) slot_age[i]++;
         end
         slot_age[s] = 0;
      endfunction

      // Lowest use count wins; among equal counts the oldest touch wins.
      function int unsigned pick_victim();
         int unsigned best;
         bit          have;
         best = 0;
         have = 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && (!have || slot_uses[i] < slot_uses[best] ||
                (slot_uses[i] == slot_uses[best] && slot_age[i] > slot_age[best]))) begin
               best = i;
               have = 1'b1;
            end
         end
         return best;
      endfunction

      function void drop_slot(int unsigned s);
         int unsigned r;
         r = slot_age[s];
         slot_live[s] = 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && slot_age[i] > r) slot_age[i]--;
         end
         if (occupancy > 0) occupancy--;
      endfunction

      // Apply one item to the model and return the result it should give.
      function lookup_outcome_type predict_outcome(logic op,
                                                   logic [lfuct_pkg::DATA_BITS-1:0] key,
                                                   logic [lfuct_pkg::DATA_BITS-1:0] value);
         lookup_outcome_type res;
         int                 found;
         int unsigned        limit;
         int unsigned        slot;
         res   = '0;
         found = -1;
         slot  = 0;
         limit = (capacity > ENTRIES) ? ENTRIES : capacity;
         for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && slot_live[i] && slot_tag[i] == key) found = i;
         end
         res.hit = (found >= 0);
         if (found >= 0) begin
            if (op == lfuct_pkg::OP_GET) begin
               res.read_value = slot_data[found];
            end else begin
               slot_data[found] = value;
            end
            // The count sticks at its maximum, but the touch still counts.
            if (slot_uses[found] != '1) slot_uses[found]++;
            touch_slot(found);
         end else if (op == lfuct_pkg::OP_GET) begin
            res.read_value = lfuct_pkg::MISS_VALUE;
         end else if (limit > 0) begin
            if (occupancy >= limit) begin
               slot            = pick_victim();
               res.evicted     = 1'b1;
               res.evicted_key = slot_tag[slot];
               drop_slot(slot);
            end else begin
               for (int i = ENTRIES - 1; i >= 0; i--) begin
                  if (!slot_live[i]) slot = i;
               end
            end
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_live[i]) slot_age[i]++;
            end
            slot_live[slot] = 1'b1;
            slot_tag[slot]  = key;
            slot_data[slot] = value;
            slot_uses[slot] = COUNT_BITS'(1);
            slot_age[slot]  = 0;
            occupancy++;
         end
         return res;
      endfunction

      function void note_request(logic op, logic [lfuct_pkg::DATA_BITS-1:0] key,
                                 logic [lfuct_pkg::DATA_BITS-1:0] value);
         awaited_outcomes.push_back(predict_outcome(op, key, value));
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTS) $display("%0t ns: %s", $time, what);
      endtask

      // Compare one accepted result item with the oldest expectation.
      task check_result(lookup_outcome_type got);
         lookup_outcome_type want;
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("result item arrived with no request outstanding");
         end else begin
            want = awaited_outcomes.pop_front();
            if (got.hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
            if (got.read_value !== want.read_value)
               report_mismatch($sformatf("read_value %h, expected %h",
                                         got.read_value, want.read_value));
            if (got.evicted !== want.evicted)
               report_mismatch($sformatf("evicted %b, expected %b",
                                         got.evicted, want.evicted));
            if (got.evicted_key !== want.evicted_key)
               report_mismatch($sformatf("evicted_key %h, expected %h",
                                         got.evicted_key, want.evicted_key));
         end
      endtask
   endclass

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [63:0]                    req_tdata  = '0;   // lookup_key, write_value
   logic                           req_tuser  = lfuct_pkg::OP_GET; // operation
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [63:0]                    rsp_tdata;         // read_value, evicted_key
   logic [1:0]                     rsp_tuser;         // hit, evicted
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [lfuct_pkg::CAP_BITS-1:0] csr_data   = '0;

   cache_scoreboard_type book;
   logic [31:0]          key_pool[KEY_POOL];
   bit                   steady_receiver = 1'b0;
   int unsigned          ready_run  = 0;
   int unsigned          stall_run  = 0;
   int unsigned          idle_cycles = 0;

   lfu_cache_table_unit #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: runs of ready cycles broken by stalls of random length.
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_run = $urandom_range(1, 16);
         if (steady_receiver || $urandom_range(0, 3) == 0) begin
            stall_run = 0;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_run = $urandom_range(5, 20);
         end else begin
            stall_run = $urandom_range(1, 3);
         end
      end
      if (stall_run > 0) begin
         stall_run--;
         rsp_tready <= 1'b0;
      end else begin
         ready_run--;
         rsp_tready <= 1'b1;
      end
   end

   // Check every result item that the receiver takes.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         book.check_result({rsp_tuser[0], rsp_tdata[31:0], rsp_tuser[1], rsp_tdata[63:32]});
      end
   end

   // Watchdog: too long without any item moving on any channel ends the run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Offer one request item and hold it until the block takes it.
   task automatic send_request(input logic op, input logic [31:0] key, input logic [31:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, key};
      do @(posedge clock); while (!req_tready);
      book.note_request(op, key, value);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait for every outstanding result item.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (book.awaited_outcomes.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Capacity changes only while the cache is idle.
   task automatic write_capacity(input logic [lfuct_pkg::CAP_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      book.set_capacity(value);
   endtask

   // Field extremes, hits and misses, updates, eviction under a lowered
   // capacity and the capacity-zero behavior.
   task automatic run_directed();
      send_request(lfuct_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(lfuct_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(lfuct_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(lfuct_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lfuct_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(lfuct_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(lfuct_pkg::OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(lfuct_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
      send_request(lfuct_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(lfuct_pkg::OP_GET, 32'h5555_5555, 32'h0000_0000);
      // Capacity below the current occupancy: each new key swaps one out.
      write_capacity(5'd2);
      send_request(lfuct_pkg::OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(lfuct_pkg::OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(lfuct_pkg::OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
      // Capacity zero: new keys are dropped, present ones still serve.
      write_capacity(5'd0);
      send_request(lfuct_pkg::OP_PUT, 32'h1357_9BDF, 32'h2468_ACE0);
      send_request(lfuct_pkg::OP_GET, 32'h1357_9BDF, 32'h0000_0000);
      send_request(lfuct_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(lfuct_pkg::OP_PUT, 32'h8000_0000, 32'h0000_0001);
      send_request(lfuct_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
   endtask

   // Raise one key's use count well above the rest, then make sure it is
   // not taken as the victim once new keys force evictions.
   task automatic run_hot_key();
      write_capacity(5'd2);
      steady_receiver = 1'b1;
      for (int n = 0; n < HOT_HITS; n++) begin
         send_request(lfuct_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      end
      send_request(lfuct_pkg::OP_PUT, 32'hC3C3_C3C3, 32'h3C3C_3C3C);
      send_request(lfuct_pkg::OP_PUT, 32'h3C3C_3C3C, 32'hC3C3_C3C3);
      send_request(lfuct_pkg::OP_PUT, 32'h8000_0000, 32'h7777_7777);
      send_request(lfuct_pkg::OP_PUT, 32'h6666_6666, 32'h9999_9999);
      steady_receiver = 1'b0;
   endtask

   // Random items in bursts: mostly keys from a shared pool so that hits,
   // count growth and evictions are common, some fresh keys as misses.
   task automatic run_random_phase(input logic [lfuct_pkg::CAP_BITS-1:0] cap,
                                   input int unsigned items);
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      int unsigned pool_span;
      logic        op;
      logic [31:0] key;
      write_capacity(cap);
      pool_span = $urandom_range(2, KEY_POOL);
      sent      = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            op  = 1'($urandom_range(0, 1));
            key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_span - 1)]
                                             : $urandom;
            send_request(op, key, $urandom);
            sent++;
         end
         if ($urandom_range(0, 39) == 0) begin
            wait_drained();
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) pause_sender(gap);
         end
      end
   endtask

   // Main sequence.
   initial begin
      book = new();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'hFFFF_FFFF;
      key_pool[3] = 32'h0000_0000;
      for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_hot_key();
      run_random_phase(5'd16, 130);
      run_random_phase(5'd4, 130);
      run_random_phase(5'd31, 130);
      run_random_phase(5'd1, 130);
      run_random_phase(5'd0, 130);
      run_random_phase(5'd7, 130);
      run_random_phase(5'd2, 130);
      run_random_phase(5'd16, 130);
      run_random_phase(5'd3, 130);
      wait_drained();
      repeat (ENTRIES + 4) @(posedge clock);
      if (book.awaited_outcomes.size() != 0) begin
         book.report_mismatch("results still outstanding at the end of the run");
      end
      if (book.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
